// File: hw/rtl/i64dm_pkg.sv
package i64dm_pkg;

  localparam int unsigned HALF_W = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned STEPS  = WORD_W;

  typedef enum logic [1:0] {
    MODE_SDIV = 2'd0,
    MODE_UDIV = 2'd1,
    MODE_SREM = 2'd2,
    MODE_UREM = 2'd3
  } i64dm_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } i64dm_status_t;

  typedef logic [WORD_W-1:0] i64dm_word_t;

  typedef struct packed {
    logic          want_rem;
    logic          neg_x;
    logic          neg_q;
    i64dm_status_t status;
  } i64dm_ctl_t;

endpackage

// File: hw/rtl/i64dm_if.sv
interface i64dm_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [i64dm_pkg::HALF_W-1:0] dividend_high;
  logic [i64dm_pkg::HALF_W-1:0] dividend_low;
  logic [i64dm_pkg::HALF_W-1:0] divisor_high;
  logic [i64dm_pkg::HALF_W-1:0] divisor_low;

  modport source (
    output valid, mode, dividend_high, dividend_low, divisor_high, divisor_low,
    input  ready
  );
  modport sink (
    input  valid, mode, dividend_high, dividend_low, divisor_high, divisor_low,
    output ready
  );
endinterface

interface i64dm_out_if;
  logic                         valid;
  logic                         ready;
  logic [i64dm_pkg::WORD_W-1:0] answer;
  logic [1:0]                   status;

  modport source (
    output valid, answer, status,
    input  ready
  );
  modport sink (
    input  valid, answer, status,
    output ready
  );
endinterface

// File: hw/rtl/i64dm_pre.sv
module i64dm_pre (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_in,
  input  logic [1:0]             mode,
  input  logic [i64dm_pkg::HALF_W-1:0] dividend_high,
  input  logic [i64dm_pkg::HALF_W-1:0] dividend_low,
  input  logic [i64dm_pkg::HALF_W-1:0] divisor_high,
  input  logic [i64dm_pkg::HALF_W-1:0] divisor_low,
  output logic                   v_out,
  output i64dm_pkg::i64dm_ctl_t  ctl_out,
  output i64dm_pkg::i64dm_word_t rem_out,
  output i64dm_pkg::i64dm_word_t quo_out,
  output i64dm_pkg::i64dm_word_t dvs_out
);

  logic                   v_r;
  i64dm_pkg::i64dm_ctl_t  ctl_r;
  i64dm_pkg::i64dm_ctl_t  ctl_nxt;
  i64dm_pkg::i64dm_word_t quo_r;
  i64dm_pkg::i64dm_word_t quo_nxt;
  i64dm_pkg::i64dm_word_t dvs_r;
  i64dm_pkg::i64dm_word_t dvs_nxt;
  i64dm_pkg::i64dm_word_t x;
  i64dm_pkg::i64dm_word_t y;
  logic                   is_signed;
  logic                   neg_y;

  always_comb begin
    x         = {dividend_high, dividend_low};
    y         = {divisor_high, divisor_low};
    is_signed = (mode == i64dm_pkg::MODE_SDIV) || (mode == i64dm_pkg::MODE_SREM);
    ctl_nxt.want_rem = (mode == i64dm_pkg::MODE_SREM) || (mode == i64dm_pkg::MODE_UREM);
    ctl_nxt.neg_x    = is_signed & x[i64dm_pkg::WORD_W-1];
    neg_y            = is_signed & y[i64dm_pkg::WORD_W-1];
    ctl_nxt.neg_q    = ctl_nxt.neg_x ^ neg_y;
    if (y == '0) begin
      ctl_nxt.status = i64dm_pkg::ST_DIV_ZERO;
    end else if (is_signed && (x == {1'b1, {(i64dm_pkg::WORD_W-1){1'b0}}}) && (y == '1)) begin
      ctl_nxt.status = i64dm_pkg::ST_OVERFLOW;
    end else begin
      ctl_nxt.status = i64dm_pkg::ST_OK;
    end
    quo_nxt = ctl_nxt.neg_x ? (~x + i64dm_pkg::i64dm_word_t'(1)) : x;
    dvs_nxt = neg_y ? (~y + i64dm_pkg::i64dm_word_t'(1)) : y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_nxt;
    end
  end

  assign v_out   = v_r;
  assign ctl_out = ctl_r;
  assign rem_out = '0;
  assign quo_out = quo_r;
  assign dvs_out = dvs_r;

endmodule

// File: hw/rtl/i64dm_step.sv
module i64dm_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_in,
  input  i64dm_pkg::i64dm_ctl_t  ctl_in,
  input  i64dm_pkg::i64dm_word_t rem_in,
  input  i64dm_pkg::i64dm_word_t quo_in,
  input  i64dm_pkg::i64dm_word_t dvs_in,
  output logic                   v_out,
  output i64dm_pkg::i64dm_ctl_t  ctl_out,
  output i64dm_pkg::i64dm_word_t rem_out,
  output i64dm_pkg::i64dm_word_t quo_out,
  output i64dm_pkg::i64dm_word_t dvs_out
);

  localparam int unsigned W = i64dm_pkg::WORD_W;

  logic                   v_r;
  i64dm_pkg::i64dm_ctl_t  ctl_r;
  i64dm_pkg::i64dm_word_t rem_r;
  i64dm_pkg::i64dm_word_t rem_nxt;
  i64dm_pkg::i64dm_word_t quo_r;
  i64dm_pkg::i64dm_word_t quo_nxt;
  i64dm_pkg::i64dm_word_t dvs_r;
  logic [W:0]             part;
  logic [W:0]             trial;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    part  = {rem_in, quo_in[W-1]};
    trial = part - {1'b0, dvs_in};
    if (!trial[W]) begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_in[W-2:0], 1'b1};
    end else begin
      rem_nxt = part[W-1:0];
      quo_nxt = {quo_in[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_in;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_in;
    end
  end

  assign v_out   = v_r;
  assign ctl_out = ctl_r;
  assign rem_out = rem_r;
  assign quo_out = quo_r;
  assign dvs_out = dvs_r;

endmodule

// File: hw/rtl/i64dm_post.sv
module i64dm_post (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   v_in,
  input  i64dm_pkg::i64dm_ctl_t  ctl_in,
  input  i64dm_pkg::i64dm_word_t rem_in,
  input  i64dm_pkg::i64dm_word_t quo_in,
  i64dm_out_if.source            out_bus
);

  logic                   take;
  logic                   valid_r;
  i64dm_pkg::i64dm_word_t answer_r;
  i64dm_pkg::i64dm_word_t answer_nxt;
  logic [1:0]             status_r;
  i64dm_pkg::i64dm_word_t pick;
  logic                   negate;

  always_comb begin
    take   = !valid_r || out_bus.ready;
    pick   = ctl_in.want_rem ? rem_in : quo_in;
    negate = ctl_in.want_rem ? ctl_in.neg_x : ctl_in.neg_q;
    if (ctl_in.status != i64dm_pkg::ST_OK) begin
      answer_nxt = '0;
    end else if (negate) begin
      answer_nxt = ~pick + i64dm_pkg::i64dm_word_t'(1);
    end else begin
      answer_nxt = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      answer_r <= answer_nxt;
      status_r <= ctl_in.status;
    end
  end

  assign out_bus.valid  = valid_r;
  assign out_bus.answer = answer_r;
  assign out_bus.status = status_r;

endmodule

// File: hw/rtl/int64_divide_modulo_unit_top.sv
// 64-bit signed and unsigned integer divider with quotient and remainder modes.
// The input channel carries one operation per beat: a mode and the dividend and
// divisor as 32-bit halves. The output channel returns one beat per operation
// with the 64-bit answer and a status code (ok, divide by zero, signed overflow);
// the answer is zero whenever the status is not ok.
// Both channels use valid/ready; a beat moves when both are high.
// The datapath is a restoring divider unrolled into 64 register stages, one
// quotient bit per stage, framed by an operand stage that takes magnitudes and
// flags the error cases and an output register that restores the signs.
// Each result is registered in the operand stage, in every step stage and in the
// output register in turn. Throughput is one beat per cycle while the output is
// not stalled, set by the one-bit-per-stage pipeline.
// When the receiver stalls, a waiting result holds in the output register while
// the pipeline keeps moving until a result reaches its last stage; only then do
// all stages freeze and in_bus.ready drops. Nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; data is not reset.
module int64_divide_modulo_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  i64dm_in_if.sink    in_bus,
  i64dm_out_if.source out_bus
);

  localparam int unsigned N = i64dm_pkg::STEPS;

  logic                   en;
  logic                   v_s   [0:N];
  i64dm_pkg::i64dm_ctl_t  ctl_s [0:N];
  i64dm_pkg::i64dm_word_t rem_s [0:N];
  i64dm_pkg::i64dm_word_t quo_s [0:N];
  i64dm_pkg::i64dm_word_t dvs_s [0:N];

  assign en           = !(v_s[N] && out_bus.valid && !out_bus.ready);
  assign in_bus.ready = en;

  i64dm_pre u_pre (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .v_in          (in_bus.valid),
    .mode          (in_bus.mode),
    .dividend_high (in_bus.dividend_high),
    .dividend_low  (in_bus.dividend_low),
    .divisor_high  (in_bus.divisor_high),
    .divisor_low   (in_bus.divisor_low),
    .v_out         (v_s[0]),
    .ctl_out       (ctl_s[0]),
    .rem_out       (rem_s[0]),
    .quo_out       (quo_s[0]),
    .dvs_out       (dvs_s[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_step
    i64dm_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (v_s[i]),
      .ctl_in  (ctl_s[i]),
      .rem_in  (rem_s[i]),
      .quo_in  (quo_s[i]),
      .dvs_in  (dvs_s[i]),
      .v_out   (v_s[i+1]),
      .ctl_out (ctl_s[i+1]),
      .rem_out (rem_s[i+1]),
      .quo_out (quo_s[i+1]),
      .dvs_out (dvs_s[i+1])
    );
  end

  i64dm_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_in    (v_s[N]),
    .ctl_in  (ctl_s[N]),
    .rem_in  (rem_s[N]),
    .quo_in  (quo_s[N]),
    .out_bus (out_bus)
  );

endmodule
